@@ src/hrhp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types and constants for the request header parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

   localparam int LengthBits = 32;
   localparam logic [31:0] LengthLimit = (LengthBits >= 32) ? 32'hFFFF_FFFF :
      32'((64'd1 << LengthBits) - 64'd1);

   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChColon = 8'h3A;
   localparam logic [7:0] ChSpace = 8'h20;

   localparam logic [1:0] PhReq   = 2'd0;
   localparam logic [1:0] PhName  = 2'd1;
   localparam logic [1:0] PhValue = 2'd2;
   localparam logic [1:0] PhSkip  = 2'd3;

   localparam logic [2:0] ClsMethod = 3'd0;
   localparam logic [2:0] ClsPath   = 3'd1;
   localparam logic [2:0] ClsVer    = 3'd2;
   localparam logic [2:0] ClsName   = 3'd3;
   localparam logic [2:0] ClsValue  = 3'd4;
   localparam logic [2:0] ClsRef    = 3'd5;
   localparam logic [2:0] ClsDelim  = 3'd6;
   localparam logic [2:0] ClsBody   = 3'd7;

   localparam logic [2:0] KindUnset = 3'd0;
   localparam logic [2:0] KindHtml  = 3'd1;
   localparam logic [2:0] KindText  = 3'd2;
   localparam logic [2:0] KindCss   = 3'd3;
   localparam logic [2:0] KindBin   = 3'd4;

   localparam logic [1:0] Ver09    = 2'd0;
   localparam logic [1:0] Ver10    = 2'd1;
   localparam logic [1:0] VerOther = 2'd2;

   localparam int QueueDepth = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first;
   } req_type;

   typedef struct packed {
      logic [2:0]  byte_class;
      logic        request_line_done;
      logic        line_error;
      logic [1:0]  version_code;
      logic [2:0]  content_kind;
      logic [31:0] length_value;
      logic        header_done;
      logic        complete;
   } rsp_type;

   // classified byte handed from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first;
      logic       is_cr;
      logic       is_lf;
      logic       is_colon;
      logic       is_space;
      logic       is_digit;
      logic       is_blank;
      logic [3:0] digit;
   } tok_type;

   function automatic logic [7:0] clen_char(input logic [3:0] pos);
      unique case (pos)
         4'd0:  clen_char = "C";
         4'd1:  clen_char = "o";
         4'd2:  clen_char = "n";
         4'd3:  clen_char = "t";
         4'd4:  clen_char = "e";
         4'd5:  clen_char = "n";
         4'd6:  clen_char = "t";
         4'd7:  clen_char = "-";
         4'd8:  clen_char = "L";
         4'd9:  clen_char = "e";
         4'd10: clen_char = "n";
         4'd11: clen_char = "g";
         4'd12: clen_char = "t";
         4'd13: clen_char = "h";
         default: clen_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] ref_char(input logic [2:0] pos);
      unique case (pos)
         3'd0: ref_char = "R";
         3'd1: ref_char = "e";
         3'd2: ref_char = "f";
         3'd3: ref_char = "e";
         3'd4: ref_char = "r";
         3'd5: ref_char = "e";
         3'd6: ref_char = "r";
         default: ref_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] ver_char(input logic [2:0] pos, input logic is10);
      unique case (pos)
         3'd0: ver_char = "H";
         3'd1: ver_char = "T";
         3'd2: ver_char = "T";
         3'd3: ver_char = "P";
         3'd4: ver_char = "/";
         3'd5: ver_char = is10 ? "1" : "0";
         3'd6: ver_char = ".";
         default: ver_char = is10 ? "0" : "9";
      endcase
   endfunction

endpackage

@@ src/http_request_header_parser_core.sv @@
// Each accepted byte is written into the token queue, and the back end then
// takes it into the output register, where its result becomes valid.
// Throughput: one byte per cycle unless a side stalls; the two-entry token
// queue and the output register let either side stall without losing a byte.
// Reset: synchronous, active high; clears the queue and all parser state.
// ----------------------------------------------------------------------------
// http_request_header_parser_core
// Byte-serial request header parser, front classifier plus back state machine.
// ----------------------------------------------------------------------------
module http_request_header_parser_core
   import hrhp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    push, full, pop_valid, pop;
   tok_type push_data, pop_data;

   hrhp_front u_front (
      .req_valid, .req_stall, .req_data,
      .tok_valid(push), .tok_full(full), .tok_data(push_data)
   );

   hrhp_queue u_queue (
      .clock, .reset, .push, .push_data, .full, .pop_valid, .pop, .pop_data
   );

   hrhp_back u_back (
      .clock, .reset, .tok_valid(pop_valid), .tok_pop(pop), .tok_data(pop_data),
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

@@ src/hrhp_front.sv @@
// ----------------------------------------------------------------------------
// hrhp_front
// Accepts request bytes and classifies each into a token for the back end.
// ----------------------------------------------------------------------------
module hrhp_front
   import hrhp_pkg::*;
(
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    tok_valid,
   input  logic    tok_full,
   output tok_type tok_data
);

   tok_type tok_in;

   always_comb begin
      tok_in           = '0;
      tok_in.data_byte = req_data.data_byte;
      tok_in.first     = req_data.first;
      tok_in.is_cr     = req_data.data_byte == ChCr;
      tok_in.is_lf     = req_data.data_byte == ChLf;
      tok_in.is_colon  = req_data.data_byte == ChColon;
      tok_in.is_space  = req_data.data_byte == ChSpace;
      tok_in.is_digit  = req_data.data_byte >= 8'h30 && req_data.data_byte <= 8'h39;
      tok_in.is_blank  = req_data.data_byte == ChSpace ||
                         (req_data.data_byte >= 8'h09 && req_data.data_byte <= 8'h0C);
      tok_in.digit     = 4'(req_data.data_byte - 8'h30);
   end

   assign req_stall = tok_full;
   assign tok_valid = req_valid && !tok_full;
   assign tok_data  = tok_in;

endmodule

@@ src/hrhp_queue.sv @@
// ----------------------------------------------------------------------------
// hrhp_queue
// Short token queue between the front and back ends.
// ----------------------------------------------------------------------------
module hrhp_queue
   import hrhp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  tok_type push_data,
   output logic    full,
   output logic    pop_valid,
   input  logic    pop,
   output tok_type pop_data
);

   tok_type    slot_ff [QueueDepth];
   tok_type    slot_in [QueueDepth];
   logic [0:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = push_data;
         wr_ptr_in          = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign full      = count_ff == 2'(QueueDepth);
   assign pop_valid = count_ff != 2'd0;
   assign pop_data  = slot_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && !pop_valid))
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) count_ff <= 2'(QueueDepth))
      else $error("queue count overflow");

endmodule

@@ src/hrhp_back.sv @@
// ----------------------------------------------------------------------------
// hrhp_back
// Parser state machine: tags each token and keeps the request status.
// ----------------------------------------------------------------------------
module hrhp_back
   import hrhp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    tok_valid,
   output logic    tok_pop,
   input  tok_type tok_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [2:0]  end_ff, end_in;
   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  part_ff, part_in;
   logic [3:0]  npos_ff, npos_in;
   logic [1:0]  nflag_ff, nflag_in;
   logic [1:0]  vphase_ff, vphase_in;
   logic [3:0]  vmatch_ff, vmatch_in;
   logic [39:0] tail_ff, tail_in;
   logic [15:0] pcount_ff, pcount_in;
   logic [31:0] accum_ff, accum_in;
   logic [31:0] body_ff, body_in;
   logic [31:0] clen_ff, clen_in;
   logic        ldone_ff, ldone_in, lerr_ff, lerr_in, hdone_ff, hdone_in;
   logic        isclen_ff, isclen_in, isref_ff, isref_in, neg_ff, neg_in;
   logic        v09_ff, v09_in, v10_ff, v10_in;
   logic [1:0]  ver_ff, ver_in;
   logic [2:0]  kind_ff, kind_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic [2:0]  cls;
   logic [35:0] mul10;
   logic        take;
   tok_type     t;

   // output register may refill while its current result leaves
   assign take    = tok_valid && (!out_valid_ff || !rsp_stall);
   assign tok_pop = take;
   assign t       = tok_data;
   assign mul10   = {4'd0, accum_ff} * 36'd10 + {32'd0, t.digit};

   always_comb begin
      end_in = end_ff; phase_in = phase_ff; part_in = part_ff;
      npos_in = npos_ff; nflag_in = nflag_ff; vphase_in = vphase_ff;
      vmatch_in = vmatch_ff; tail_in = tail_ff; pcount_in = pcount_ff;
      accum_in = accum_ff; body_in = body_ff; clen_in = clen_ff;
      ldone_in = ldone_ff; lerr_in = lerr_ff; hdone_in = hdone_ff;
      isclen_in = isclen_ff; isref_in = isref_ff; neg_in = neg_ff;
      v09_in = v09_ff; v10_in = v10_ff; ver_in = ver_ff; kind_in = kind_ff;
      cls = ClsDelim;
      if (t.first) begin
         end_in = '0; phase_in = PhReq; part_in = '0; npos_in = '0;
         nflag_in = 2'b11; vphase_in = '0; vmatch_in = '0; tail_in = '0;
         pcount_in = '0; accum_in = '0; body_in = '0; clen_in = '0;
         ldone_in = 1'b0; lerr_in = 1'b0; hdone_in = 1'b0; isclen_in = 1'b0;
         isref_in = 1'b0; neg_in = 1'b0; v09_in = 1'b1; v10_in = 1'b1;
         ver_in = Ver09; kind_in = KindUnset;
      end
      if (hdone_in) begin
         cls = ClsBody;
         if (body_in != 32'hFFFF_FFFF) body_in = body_in + 32'd1;
      end else begin
         unique case (end_in)
            3'd0: end_in = t.is_cr ? 3'd1 : 3'd0;
            3'd1: end_in = t.is_lf ? 3'd2 : 3'd0;
            3'd2: end_in = t.is_cr ? 3'd3 : 3'd0;
            3'd3: end_in = t.is_lf ? 3'd4 : 3'd0;
            default: end_in = 3'd4;
         endcase
         unique case (phase_in)
            PhReq: begin
               if (t.is_cr) begin
                  ldone_in = 1'b1;
                  if (part_in != 2'd2) begin
                     lerr_in = 1'b1; ver_in = VerOther;
                  end else if (vmatch_in == 4'd8 && v09_in) ver_in = Ver09;
                  else if (vmatch_in == 4'd8 && v10_in) ver_in = Ver10;
                  else ver_in = VerOther;
                  if (pcount_in > 16'd5) begin
                     if (tail_in == 40'h2E68746D6C) kind_in = KindHtml;
                     else if (tail_in[31:0] == 32'h2E68746D) kind_in = KindHtml;
                     else if (tail_in[31:0] == 32'h2E747874) kind_in = KindText;
                     else if (tail_in[31:0] == 32'h2E637373) kind_in = KindCss;
                     else kind_in = KindBin;
                  end
                  phase_in = PhSkip;
               end else if (part_in == 2'd0) begin
                  if (t.is_space) part_in = 2'd1; else cls = ClsMethod;
               end else if (part_in == 2'd1) begin
                  if (t.is_space) part_in = 2'd2;
                  else begin
                     cls = ClsPath;
                     tail_in = {tail_in[31:0], t.data_byte};
                     if (pcount_in != 16'hFFFF) pcount_in = pcount_in + 16'd1;
                  end
               end else begin
                  cls = ClsVer;
                  if (vmatch_in < 4'd8) begin
                     if (t.data_byte != ver_char(vmatch_in[2:0], 1'b0)) v09_in = 1'b0;
                     if (t.data_byte != ver_char(vmatch_in[2:0], 1'b1)) v10_in = 1'b0;
                  end
                  if (vmatch_in < 4'd9) vmatch_in = vmatch_in + 4'd1;
               end
            end
            PhName: begin
               if (t.is_cr) phase_in = PhSkip;
               else if (t.is_colon) begin
                  isclen_in = nflag_in[0] && npos_in == 4'd14;
                  isref_in  = nflag_in[1] && npos_in == 4'd7;
                  neg_in = 1'b0; vphase_in = '0; accum_in = '0; phase_in = PhValue;
               end else begin
                  cls = ClsName;
                  if (npos_in >= 4'd14 || t.data_byte != clen_char(npos_in))
                     nflag_in[0] = 1'b0;
                  if (npos_in >= 4'd7 || t.data_byte != ref_char(npos_in[2:0]))
                     nflag_in[1] = 1'b0;
                  if (npos_in < 4'd15) npos_in = npos_in + 4'd1;
               end
            end
            PhValue: begin
               if (t.is_cr) begin
                  if (isclen_in) clen_in = neg_in ? 32'd0 : accum_in;
                  phase_in = PhSkip;
               end else begin
                  cls = isref_in ? ClsRef : ClsValue;
                  if (isclen_in) begin
                     unique case (vphase_in)
                        2'd0: begin
                           if (!t.is_blank) begin
                              if (t.data_byte == 8'h2B) vphase_in = 2'd1;
                              else if (t.data_byte == 8'h2D) begin
                                 neg_in = 1'b1; vphase_in = 2'd1;
                              end else if (t.is_digit) begin
                                 accum_in = {28'd0, t.digit}; vphase_in = 2'd2;
                              end else vphase_in = 2'd3;
                           end
                        end
                        2'd1, 2'd2: begin
                           if (t.is_digit) begin
                              accum_in = (mul10 > {4'd0, LengthLimit}) ? LengthLimit
                                                                       : mul10[31:0];
                              vphase_in = 2'd2;
                           end else vphase_in = 2'd3;
                        end
                        default: ;
                     endcase
                  end
               end
            end
            default: begin
               phase_in = PhName; npos_in = '0; nflag_in = 2'b11;
            end
         endcase
         if (end_in == 3'd4) begin
            hdone_in = 1'b1; cls = ClsDelim;
         end
      end
      out_in = '{byte_class: cls, request_line_done: ldone_in, line_error: lerr_in,
                 version_code: ver_in, content_kind: kind_in,
                 length_value: clen_in, header_done: hdone_in,
                 complete: hdone_in && body_in >= clen_in};
      out_valid_in = take || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         end_ff <= '0; phase_ff <= PhReq; part_ff <= '0; npos_ff <= '0;
         nflag_ff <= 2'b11; vphase_ff <= '0; vmatch_ff <= '0; tail_ff <= '0;
         pcount_ff <= '0; accum_ff <= '0; body_ff <= '0; clen_ff <= '0;
         ldone_ff <= 1'b0; lerr_ff <= 1'b0; hdone_ff <= 1'b0;
         isclen_ff <= 1'b0; isref_ff <= 1'b0; neg_ff <= 1'b0;
         v09_ff <= 1'b1; v10_ff <= 1'b1; ver_ff <= Ver09; kind_ff <= KindUnset;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            out_ff <= out_in;
            tail_ff <= tail_in; pcount_ff <= pcount_in; accum_ff <= accum_in;
            body_ff <= body_in; clen_ff <= clen_in; npos_ff <= npos_in;
            nflag_ff <= nflag_in; vphase_ff <= vphase_in; vmatch_ff <= vmatch_in;
            isclen_ff <= isclen_in; isref_ff <= isref_in; neg_ff <= neg_in;
            v09_ff <= v09_in; v10_ff <= v10_in; ver_ff <= ver_in; kind_ff <= kind_in;
            part_ff <= part_in; end_ff <= end_in; phase_ff <= phase_in;
            ldone_ff <= ldone_in; lerr_ff <= lerr_in; hdone_ff <= hdone_in;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result lost");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.complete |-> rsp_data.header_done)
      else $error("complete without header done");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.line_error |-> rsp_data.request_line_done &&
      rsp_data.version_code == VerOther)
      else $error("line error without line done");

endmodule
